[hdl/printable_string_extractor_assert.svh]
// Assertion macros for the printable string extractor.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef PRINTABLE_STRING_EXTRACTOR_ASSERT_SVH
`define PRINTABLE_STRING_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pse assertion failed");

// Next-cycle implication, checked outside reset
`define PSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pse assertion failed");

`endif

[hdl/pse_pkg.sv]
// Shared types and constants for the printable string extractor.
// No dependencies; imported by every module of the block.
package pse_pkg;

    localparam int MAX_RUN     = 64;
    localparam int RUN_LEN_W   = $clog2(MAX_RUN + 1);
    localparam int RUN_IDX_W   = $clog2(MAX_RUN);
    localparam int RING_DEPTH  = 2 * MAX_RUN;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int LENQ_DEPTH  = 4;
    localparam int LENQ_AW     = $clog2(LENQ_DEPTH);
    localparam int LENQ_CW     = $clog2(LENQ_DEPTH + 1);

    localparam logic [6:0]  MIN_LENGTH_RST   = 7'd4;
    localparam logic [6:0]  MAX_LENGTH_RST   = 7'd64;
    localparam logic [31:0] SEARCH_LIMIT_RST = 32'd1048576;
    localparam logic [9:0]  STRING_LIMIT_RST = 10'd1000;

    typedef enum logic [1:0] {
        CFG_MIN_LENGTH,
        CFG_MAX_LENGTH,
        CFG_SEARCH_LIMIT,
        CFG_STRING_LIMIT
    } pse_cfg_idx_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } pse_byte_t;

    typedef struct packed {
        logic [6:0] char_code;
        logic       string_last;
    } pse_char_t;

    typedef struct packed {
        logic [6:0]  min_length;
        logic [6:0]  max_length;
        logic [31:0] search_limit;
        logic [9:0]  string_limit;
    } pse_cfg_t;

    // Character write into the ring buffer
    typedef struct packed {
        logic               en;
        logic [RING_AW-1:0] addr;
        logic [6:0]         code;
    } pse_wr_t;

    // String request to the length queue: length minus one
    typedef struct packed {
        logic                 push;
        logic [RUN_IDX_W-1:0] len_m1;
    } pse_cmd_t;

    typedef struct packed {
        logic [RING_AW:0] wr_ptr;
    } pse_front_st_t;

endpackage

[hdl/pse_front.sv]
// Front end: accepts bytes, tracks runs and counters, writes the ring buffer.
// Depends on pse_pkg; issues string requests to pse_lenq.
module pse_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pse_pkg::pse_cfg_t         cfg,
    input  logic                      byte_valid,
    output logic                      byte_stall,
    input  pse_pkg::pse_byte_t        byte_data,
    input  logic [pse_pkg::RING_AW:0] rd_ptr,
    input  logic                      q_full,
    output pse_pkg::pse_wr_t          wr,
    output pse_pkg::pse_cmd_t         cmd,
    output pse_pkg::pse_front_st_t    status
);
    import pse_pkg::*;

    logic [RING_AW:0]   run_start_reg, run_start_next;
    logic [RUN_LEN_W-1:0] run_len_reg, run_len_next;
    logic [31:0]        byte_pos_reg, byte_pos_next;
    logic [9:0]         str_cnt_reg, str_cnt_next;

    logic [RING_AW:0]   wr_ptr;
    logic [RING_AW:0]   occupancy;
    logic               accept;
    logic               in_window;
    logic               window_end;
    logic               printable;
    logic [RUN_LEN_W-1:0] len_after;
    logic [RUN_LEN_W-1:0] min_eff;
    logic [RUN_LEN_W-1:0] max_eff;
    logic               flush;
    logic               emit;

    assign wr_ptr     = run_start_reg + {{(RING_AW + 1 - RUN_LEN_W){1'b0}}, run_len_reg};
    assign occupancy  = wr_ptr - rd_ptr;
    // Hold input while the ring is full or no queue slot remains for a string
    assign byte_stall = (occupancy == (RING_AW + 1)'(RING_DEPTH)) || q_full;
    assign accept     = byte_valid && !byte_stall;

    assign min_eff = (cfg.min_length == 7'd0) ? RUN_LEN_W'(1) : RUN_LEN_W'(cfg.min_length);
    assign max_eff = (cfg.max_length > 7'(MAX_RUN)) ? RUN_LEN_W'(MAX_RUN)
                                                    : RUN_LEN_W'(cfg.max_length);

    assign in_window  = byte_pos_reg < cfg.search_limit;
    assign window_end = ({1'b0, byte_pos_reg} + 33'd1) == {1'b0, cfg.search_limit};
    assign printable  = (byte_data.data_byte >= 8'h20) && (byte_data.data_byte <= 8'h7E);
    assign len_after  = run_len_reg + (printable ? RUN_LEN_W'(1) : RUN_LEN_W'(0));

    // At most one string leaves per byte: any second flush sees an empty run
    assign flush = (printable ? (len_after >= max_eff) : 1'b1)
                   || byte_data.end_of_data || window_end;
    assign emit  = in_window && flush && (len_after >= min_eff)
                   && (str_cnt_reg < cfg.string_limit);

    assign wr.en      = accept && in_window && printable;
    assign wr.addr    = wr_ptr[RING_AW-1:0];
    assign wr.code    = byte_data.data_byte[6:0];
    assign cmd.push   = accept && emit;
    assign cmd.len_m1 = RUN_IDX_W'(len_after - RUN_LEN_W'(1));
    assign status.wr_ptr = wr_ptr;

    always_comb
    begin
        run_start_next = run_start_reg;
        run_len_next   = run_len_reg;
        byte_pos_next  = byte_pos_reg;
        str_cnt_next   = str_cnt_reg;
        if (accept)
        begin
            if (in_window)
            begin
                if (flush)
                begin
                    // Commit the run on emit, otherwise rewind over it
                    if (emit)
                    begin
                        run_start_next = run_start_reg
                                         + {{(RING_AW + 1 - RUN_LEN_W){1'b0}}, len_after};
                        str_cnt_next   = str_cnt_reg + 10'd1;
                    end
                    run_len_next = '0;
                end
                else
                begin
                    run_len_next = len_after;
                end
            end
            if (byte_pos_reg != 32'hFFFF_FFFF)
            begin
                byte_pos_next = byte_pos_reg + 32'd1;
            end
            if (byte_data.end_of_data)
            begin
                run_len_next  = '0;
                byte_pos_next = '0;
                str_cnt_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_start_reg <= '0;
            run_len_reg   <= '0;
            byte_pos_reg  <= '0;
            str_cnt_reg   <= '0;
        end
        else
        begin
            run_start_reg <= run_start_next;
            run_len_reg   <= run_len_next;
            byte_pos_reg  <= byte_pos_next;
            str_cnt_reg   <= str_cnt_next;
        end
    end

endmodule

[hdl/pse_lenq.sv]
// Short queue of string lengths between the front end and the back end.
// Depends on pse_pkg.
module pse_lenq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pse_pkg::pse_cmd_t             cmd,
    input  logic                          pop,
    output logic                          q_valid,
    output logic                          q_full,
    output logic [pse_pkg::RUN_IDX_W-1:0] q_len_m1
);
    import pse_pkg::*;

    logic [RUN_IDX_W-1:0] slot_reg [LENQ_DEPTH];
    logic [LENQ_AW-1:0]   wp_reg, wp_next;
    logic [LENQ_AW-1:0]   rp_reg, rp_next;
    logic [LENQ_CW-1:0]   cnt_reg, cnt_next;
    logic                 do_push;
    logic                 do_pop;

    assign q_full   = cnt_reg == LENQ_CW'(LENQ_DEPTH);
    assign q_valid  = cnt_reg != '0;
    assign q_len_m1 = slot_reg[rp_reg];
    assign do_push  = cmd.push && !q_full;
    assign do_pop   = pop && q_valid;

    always_comb
    begin
        wp_next  = do_push ? wp_reg + LENQ_AW'(1) : wp_reg;
        rp_next  = do_pop ? rp_reg + LENQ_AW'(1) : rp_reg;
        cnt_next = cnt_reg + (do_push ? LENQ_CW'(1) : '0) - (do_pop ? LENQ_CW'(1) : '0);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wp_reg] <= cmd.len_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[hdl/pse_back.sv]
// Back end: holds the character ring and drains committed strings to the output.
// Depends on pse_pkg; takes string lengths from pse_lenq.
module pse_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pse_pkg::pse_wr_t              wr,
    input  logic                          q_valid,
    input  logic [pse_pkg::RUN_IDX_W-1:0] q_len_m1,
    output logic                          pop,
    output logic [pse_pkg::RING_AW:0]     rd_ptr,
    output logic                          char_valid,
    input  logic                          char_stall,
    output pse_pkg::pse_char_t            char_data
);
    import pse_pkg::*;

    logic [6:0]           ring_mem [RING_DEPTH];
    logic [6:0]           rd_q_reg;
    logic                 active_reg, active_next;
    logic [RUN_LEN_W-1:0] rem_reg, rem_next;
    logic [RING_AW:0]     rd_ptr_reg, rd_ptr_next;
    logic                 pend_reg, pend_next;
    logic                 pend_last_reg, pend_last_next;
    logic                 out_valid_reg, out_valid_next;
    pse_char_t            out_reg, out_next;
    logic                 out_free;
    logic                 issue;

    assign out_free = !out_valid_reg || !char_stall;
    // Read only when nothing is in flight, so the fetched char always finds the output free
    assign issue    = active_reg && !pend_reg && out_free;
    assign pop      = !active_reg && q_valid;

    assign rd_ptr     = rd_ptr_reg;
    assign char_valid = out_valid_reg;
    assign char_data  = out_reg;

    always_comb
    begin
        active_next    = active_reg;
        rem_next       = rem_reg;
        rd_ptr_next    = rd_ptr_reg;
        pend_next      = 1'b0;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (pop)
        begin
            active_next = 1'b1;
            rem_next    = RUN_LEN_W'(q_len_m1) + RUN_LEN_W'(1);
        end
        if (issue)
        begin
            rem_next       = rem_reg - RUN_LEN_W'(1);
            active_next    = rem_reg != RUN_LEN_W'(1);
            rd_ptr_next    = rd_ptr_reg + (RING_AW + 1)'(1);
            pend_next      = 1'b1;
            pend_last_next = rem_reg == RUN_LEN_W'(1);
        end
        if (pend_reg)
        begin
            out_valid_next       = 1'b1;
            out_next.char_code   = rd_q_reg;
            out_next.string_last = pend_last_reg;
        end
        else if (!char_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            ring_mem[wr.addr] <= wr.code;
        end
        if (issue)
        begin
            rd_q_reg <= ring_mem[rd_ptr_reg[RING_AW-1:0]];
        end
        pend_last_reg <= pend_last_next;
        out_reg       <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            rem_reg       <= '0;
            rd_ptr_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            rem_reg       <= rem_next;
            rd_ptr_reg    <= rd_ptr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hdl/printable_string_extractor.sv]
// Path: string length -> length queue -> back end pop -> ring read (rd_q_reg) -> out_reg.
// Throughput: one input byte per cycle while the 128-char ring and the 4-entry length
// queue have room; output drains one char at a time, as each ring read waits for the
// last char to reach out_reg. Sustained rate is bounded by the output drain.
// Reset: counters, pointers, queue and config registers clear to defaults at once;
// the ring memory is not cleared and needs no clearing pass.
module printable_string_extractor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  pse_pkg::pse_byte_t byte_data,
    output logic               char_valid,
    input  logic               char_stall,
    output pse_pkg::pse_char_t char_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import pse_pkg::*;
    `include "printable_string_extractor_assert.svh"

    pse_cfg_t             cfg_reg, cfg_next;
    pse_wr_t              wr;
    pse_cmd_t             cmd;
    pse_front_st_t        front_st;
    logic [RING_AW:0]     rd_ptr;
    logic                 q_valid;
    logic                 q_full;
    logic [RUN_IDX_W-1:0] q_len_m1;
    logic                 pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (pse_cfg_idx_t'(cfg_index))
                CFG_MIN_LENGTH:   cfg_next.min_length   = cfg_data[6:0];
                CFG_MAX_LENGTH:   cfg_next.max_length   = cfg_data[6:0];
                CFG_SEARCH_LIMIT: cfg_next.search_limit = cfg_data;
                CFG_STRING_LIMIT: cfg_next.string_limit = cfg_data[9:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_length   <= MIN_LENGTH_RST;
            cfg_reg.max_length   <= MAX_LENGTH_RST;
            cfg_reg.search_limit <= SEARCH_LIMIT_RST;
            cfg_reg.string_limit <= STRING_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .rd_ptr     (rd_ptr),
        .q_full     (q_full),
        .wr         (wr),
        .cmd        (cmd),
        .status     (front_st)
    );

    pse_lenq u_lenq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .q_len_m1 (q_len_m1)
    );

    pse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .q_valid    (q_valid),
        .q_len_m1   (q_len_m1),
        .pop        (pop),
        .rd_ptr     (rd_ptr),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data)
    );

    `PSE_ASSERT_NOW(a_ring_bound, 1'b1,
        (front_st.wr_ptr - rd_ptr) <= (RING_AW + 1)'(RING_DEPTH))
    `PSE_ASSERT_NOW(a_no_push_full, cmd.push, !q_full)
    `PSE_ASSERT_NOW(a_char_printable, char_valid,
        (char_data.char_code >= 7'h20) && (char_data.char_code <= 7'h7E))
    `PSE_ASSERT_NEXT(a_pop_then_busy, pop, !pop)

endmodule

[tb/sv/printable_string_extractor_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for printable_string_extractor: predicts extracted strings per byte
// and checks every emitted character in order. Depends on pse_pkg and the block's RTL only.
module printable_string_extractor_test;
    import pse_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_BYTES  = 60;
    localparam int SETTLE_CYCLES = 8;

    class extracted_string_board;
        logic [6:0]  min_length;
        logic [6:0]  max_length;
        logic [31:0] search_limit;
        logic [9:0]  string_limit;
        logic [7:0]  run_buf [MAX_RUN];
        int unsigned run_len;
        logic [31:0] byte_pos;
        logic [9:0]  strings_done;
        pse_char_t   pending_chars [$];
        int          mismatch_count;
        int          chars_checked;
        int          strings_checked;

        function new();
            min_length      = MIN_LENGTH_RST;
            max_length      = MAX_LENGTH_RST;
            search_limit    = SEARCH_LIMIT_RST;
            string_limit    = STRING_LIMIT_RST;
            run_len         = 0;
            byte_pos        = '0;
            strings_done    = '0;
            mismatch_count  = 0;
            chars_checked   = 0;
            strings_checked = 0;
        endfunction

        function void write_reg(pse_cfg_idx_t idx, logic [31:0] value);
            case (idx)
                CFG_MIN_LENGTH:   min_length   = value[6:0];
                CFG_MAX_LENGTH:   max_length   = value[6:0];
                CFG_SEARCH_LIMIT: search_limit = value;
                CFG_STRING_LIMIT: string_limit = value[9:0];
                default: ;
            endcase
        endfunction

        // Emit the current run if long enough and under the string limit, then clear it
        function void flush_run();
            int unsigned min_eff;
            pse_char_t   c;
            min_eff = (min_length == 0) ? 1 : min_length;
            if (run_len >= min_eff && run_len > 0 && strings_done < string_limit)
            begin
                for (int unsigned i = 0; i < run_len; i++)
                begin
                    c.char_code   = run_buf[i][6:0];
                    c.string_last = (i + 1 == run_len);
                    pending_chars = {pending_chars, c};
                end
                strings_done++;
            end
            run_len = 0;
        endfunction

        function void note_byte(pse_byte_t item);
            int unsigned max_eff;
            logic        printable;
            max_eff   = (max_length > MAX_RUN) ? MAX_RUN : max_length;
            printable = item.data_byte >= 8'h20 && item.data_byte <= 8'h7E;
            if (byte_pos < search_limit)
            begin
                if (printable)
                begin
                    if (run_len < MAX_RUN)
                    begin
                        run_buf[run_len] = item.data_byte;
                        run_len++;
                    end
                    if (run_len >= max_eff)
                        flush_run();
                end
                else
                    flush_run();
                // End of data or the last searched byte closes the window
                if (item.end_of_data || {1'b0, byte_pos} + 33'd1 == {1'b0, search_limit})
                    flush_run();
            end
            if (byte_pos != '1)
                byte_pos++;
            if (item.end_of_data)
            begin
                run_len      = 0;
                byte_pos     = '0;
                strings_done = '0;
            end
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_char(pse_char_t got);
            pse_char_t want;
            if (pending_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character 0x%02h", got.char_code));
                return;
            end
            want = pending_chars.pop_front();
            chars_checked++;
            if (got.char_code !== want.char_code)
                report_mismatch($sformatf("char_code 0x%02h, predicted 0x%02h",
                                          got.char_code, want.char_code));
            if (got.string_last !== want.string_last)
                report_mismatch($sformatf("string_last %b, predicted %b",
                                          got.string_last, want.string_last));
            else if (want.string_last)
                strings_checked++;
        endtask

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    pse_byte_t   byte_data  = '0;
    logic        char_valid;
    logic        char_stall = 1'b0;
    pse_char_t   char_data;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index  = '0;
    logic [31:0] cfg_data   = '0;

    logic        tx_idle_on  = 1'b1;
    logic        rx_idle_on  = 1'b1;
    logic        hold_active = 1'b0;
    int unsigned cycle_count = 0;
    int          bytes_sent  = 0;
    int          random_bytes = 0;
    int          settings_count = 0;

    extracted_string_board board = new();

    printable_string_extractor i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycle_count, board.pending());
            $display("FAIL printable_string_extractor");
            $finish;
        end
    end

    always @(posedge clk)
        char_stall <= hold_active || (rx_idle_on && $urandom_range(99) < 26);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
                board.note_byte(byte_data);
            if (char_valid && !char_stall)
                board.check_char(char_data);
        end
    end

    task send_byte(input logic [7:0] value, input logic last);
        pse_byte_t item;
        item.data_byte   = value;
        item.end_of_data = last;
        // Idle a random number of cycles, about a quarter of all cycles
        while (tx_idle_on && $urandom_range(99) < 26)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_data  <= item;
        byte_valid <= 1'b1;
        do @(posedge clk); while (byte_stall);
        bytes_sent++;
    endtask

    task send_text(input string text, input logic close);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i], close && i == text.len() - 1);
    endtask

    function logic [7:0] pick_printable();
        return 8'($urandom_range(8'h7E, 8'h20));
    endfunction

    function logic [7:0] pick_separator();
        return $urandom_range(1) ? 8'($urandom_range(8'h1F, 8'h00))
                                 : 8'($urandom_range(8'hFF, 8'h7F));
    endfunction

    // One data set: printable runs split by non-printable bytes, or plain noise
    task send_set(input int length, input logic noisy);
        int         run_left;
        logic [7:0] value;
        run_left = ($urandom_range(9) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 10);
        for (int i = 0; i < length; i++)
        begin
            if (noisy)
                value = 8'($urandom_range(255));
            else if (run_left == 0)
            begin
                value    = pick_separator();
                run_left = ($urandom_range(9) == 0) ? $urandom_range(55, 70)
                                                    : $urandom_range(1, 10);
            end
            else
            begin
                value = pick_printable();
                run_left--;
            end
            send_byte(value, i == length - 1);
            random_bytes++;
        end
    endtask

    // Drop valid, wait for every predicted character, then let the pipeline settle
    task drain();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task put_reg(input pse_cfg_idx_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, value);
    endtask

    task write_config(input logic [31:0] min_v, input logic [31:0] max_v,
                      input logic [31:0] search_v, input logic [31:0] limit_v);
        put_reg(CFG_MIN_LENGTH, min_v);
        put_reg(CFG_MAX_LENGTH, max_v);
        put_reg(CFG_SEARCH_LIMIT, search_v);
        put_reg(CFG_STRING_LIMIT, limit_v);
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    task random_config();
        logic [31:0] min_v;
        logic [31:0] max_v;
        logic [31:0] search_v;
        logic [31:0] limit_v;
        logic [31:0] junk;
        case ($urandom_range(9))
            0:       min_v = 0;
            1:       min_v = 64;
            2:       min_v = 127;
            default: min_v = $urandom_range(1, 6);
        endcase
        case ($urandom_range(9))
            0:       max_v = 0;
            1:       max_v = 64;
            2:       max_v = $urandom_range(65, 127);
            3:       max_v = $urandom_range(1, 3);
            default: max_v = $urandom_range(4, 20);
        endcase
        case ($urandom_range(9))
            0:       search_v = 0;
            1:       search_v = 32'hFFFF_FFFF;
            2, 3:    search_v = $urandom_range(1, 30);
            4:       search_v = $urandom();
            default: search_v = SEARCH_LIMIT_RST;
        endcase
        case ($urandom_range(9))
            0:       limit_v = 0;
            1:       limit_v = 1023;
            2, 3:    limit_v = $urandom_range(1, 3);
            default: limit_v = STRING_LIMIT_RST;
        endcase
        // Bits above each register's width are ignored by the block
        junk = $urandom_range(1) ? $urandom() : 32'd0;
        write_config(min_v | (junk & 32'hFFFF_FF80), max_v | (junk & 32'hFFFF_FF80),
                     search_v, limit_v | (junk & 32'hFFFF_FC00));
    endtask

    task hold_off();
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    endtask

    initial
    begin
        int phase_no;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults: field extremes, short run dropped, run closed by end of data
        send_byte(8'h20, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_text("AB", 1'b0);
        send_byte(8'h1F, 1'b0);
        send_text("ab", 1'b0);
        send_byte(8'h7F, 1'b0);
        send_text("wxyz", 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        drain();

        // Zero min and max lengths, search window of three, two strings allowed
        write_config(0, 0, 3, 2);
        send_text("abcdA", 1'b1);
        drain();

        // Nothing searched, nothing allowed
        write_config(9, 100, 0, 0);
        send_text("hi", 1'b1);
        drain();

        // Minimum above the cut length
        write_config(8, 5, 32'hFFFF_FFFF, 1023);
        send_text("pqrst", 1'b0);
        send_byte(8'h00, 1'b1);
        drain();

        // Hold the output while short strings fill the length queue and stall the input
        write_config(4, 100, 32'hFFFF_FFFF, 1023);
        fork
            hold_off();
            begin
                for (int k = 0; k < 8; k++)
                begin
                    for (int j = 0; j < 5; j++)
                        send_byte(pick_printable(), 1'b0);
                    send_byte(pick_separator(), k == 7);
                end
            end
        join
        drain();

        phase_no = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            // First random phase runs with no idling on either side
            tx_idle_on <= (phase_no != 0);
            rx_idle_on <= (phase_no != 0);
            random_config();
            repeat ($urandom_range(1, 3))
                send_set(($urandom_range(5) == 0) ? $urandom_range(40, 80) : $urandom_range(3, 30),
                         $urandom_range(6) == 0);
            drain();
            phase_no++;
        end

        $display("Sent %0d bytes under %0d register settings, one %0d-cycle output hold-off",
                 bytes_sent, settings_count, HOLD_CYCLES);
        $display("Checked %0d characters in %0d strings, %0d mismatches",
                 board.chars_checked, board.strings_checked, board.mismatch_count);
        if (board.mismatch_count == 0)
            $display("PASS printable_string_extractor");
        else
            $display("FAIL printable_string_extractor");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/pse_pkg.sv
hdl/pse_front.sv
hdl/pse_lenq.sv
hdl/pse_back.sv
hdl/printable_string_extractor.sv
tb/sv/printable_string_extractor_test.sv
